FILE: hw/rtl/dtb_pkg.sv
`default_nettype none

package dtb_pkg;

    // fixed field widths
    localparam int ROW_W = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int IDOM_W = IDX_W + 1;

    localparam int DEF_MAX_NODES = 64;

    // sequencer states, one-hot
    typedef enum logic [20:0] {
        ST_IDLE   = 21'h000001,
        ST_INIT   = 21'h000002,
        ST_D_PRD  = 21'h000004,
        ST_D_PROW = 21'h000008,
        ST_D_JRD  = 21'h000010,
        ST_D_JUSE = 21'h000020,
        ST_D_ORD  = 21'h000040,
        ST_D_WR   = 21'h000080,
        ST_I_RRD  = 21'h000100,
        ST_I_ROW  = 21'h000200,
        ST_I_JRD  = 21'h000400,
        ST_I_JUSE = 21'h000800,
        ST_I_WR   = 21'h001000,
        ST_F_RD   = 21'h002000,
        ST_F_ROW  = 21'h004000,
        ST_F_J    = 21'h008000,
        ST_F_WRD  = 21'h010000,
        ST_F_WUSE = 21'h020000,
        ST_O_RD   = 21'h040000,
        ST_O_LOAD = 21'h080000,
        ST_CLR    = 21'h100000
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dominator_tree_builder.sv
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  edge_valid, edge_from, edge_to, final_item
// out       output     out_valid/out_stall  node_index .. last_node, one per node
// cfg       input      cfg_valid/cfg_ready  cfg_data (node_count)
//
// edges are accepted only while idle; the final item starts the analysis and the
// input stalls until the clear state that follows the loading of the last result.
// the dominator fixpoint reads every node's row for each node on each pass through
// the single dominator memory read port; idom selection scans every row per node,
// frontier walks follow the idom chain step by step, output goes node by node.
// reset is asynchronous active low; out_stall holds the output register and stalls the output load state.

module dominator_tree_builder #(
    parameter int MAX_NODES = dtb_pkg::DEF_MAX_NODES
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [dtb_pkg::CNT_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      edge_valid,
    input  wire logic [dtb_pkg::IDX_W-1:0] edge_from,
    input  wire logic [dtb_pkg::IDX_W-1:0] edge_to,
    input  wire logic                      final_item,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [dtb_pkg::IDX_W-1:0]      node_index,
    output logic [dtb_pkg::ROW_W-1:0]      dominator_set,
    output logic                           idom_present,
    output logic [dtb_pkg::IDX_W-1:0]      immediate_dominator,
    output logic [dtb_pkg::ROW_W-1:0]      frontier_set,
    output logic                           last_node
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RW = dtb_pkg::ROW_W;
    localparam int XW = dtb_pkg::IDX_W;
    localparam int CW = dtb_pkg::CNT_W;
    localparam int DW = dtb_pkg::IDOM_W;

    // memories
    logic [RW-1:0] pred_mem [MAX_NODES];
    logic [RW-1:0] dom_mem  [MAX_NODES];
    logic [DW-1:0] idom_mem [MAX_NODES];
    logic [RW-1:0] fr_mem   [MAX_NODES];
    logic [MAX_NODES-1:0] pred_vld_reg;
    logic [MAX_NODES-1:0] fr_vld_reg;

    logic [RW-1:0] pred_rd_reg, dom_rd_reg, fr_rd_reg;
    logic [DW-1:0] idom_rd_reg;
    logic          pv_rd_reg, fv_rd_reg;

    // control
    dtb_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cfg_n_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [XW-1:0] cur_reg, cur_next;
    logic          cv_reg, cv_next;
    logic          changed_reg, changed_next;
    logic          have_reg, have_next;
    logic [XW-1:0] pick_reg, pick_next;
    logic [RW-1:0] full_reg, full_next;
    logic [RW-1:0] prow_reg, prow_next;
    logic [RW-1:0] acc_reg, acc_next;
    logic [DW-1:0] idi_reg, idi_next;

    // output register
    logic          ov_reg;
    logic [XW-1:0] o_idx_reg;
    logic [RW-1:0] o_dom_reg, o_fr_reg;
    logic          o_ip_reg, o_last_reg;
    logic [XW-1:0] o_id_reg;

    logic          in_xfer, out_free, o_load;
    logic [IW-1:0] dom_raddr, idom_raddr;
    logic [IW-1:0] i_a, j_a, cur_a;
    logic [RW-1:0] i_bit, dom_new;
    logic [CW-1:0] cfg_sat;

    assign i_a   = i_reg[IW-1:0];
    assign j_a   = j_reg[IW-1:0];
    assign cur_a = cur_reg[IW-1:0];
    assign i_bit = RW'(1) << i_reg[XW-1:0];
    assign dom_new = acc_reg | i_bit;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != dtb_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !ov_reg || !out_stall;
    assign o_load    = (state_reg == dtb_pkg::ST_O_LOAD) && out_free;

    // node count saturation
    always_comb
    begin
        if (cfg_data == '0)
            cfg_sat = CW'(1);
        else if (cfg_data > CW'(MAX_NODES))
            cfg_sat = CW'(MAX_NODES);
        else
            cfg_sat = cfg_data;
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_n_reg <= CW'(1);
        else if (cfg_valid && cfg_ready)
            cfg_n_reg <= cfg_sat;
    end

    // read address select
    always_comb
    begin
        if (state_reg == dtb_pkg::ST_D_JRD || state_reg == dtb_pkg::ST_I_JRD)
            dom_raddr = j_a;
        else
            dom_raddr = i_a;
        if (state_reg == dtb_pkg::ST_F_WRD)
            idom_raddr = cur_a;
        else
            idom_raddr = i_a;
    end

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        pred_rd_reg <= pred_mem[i_a];
        dom_rd_reg  <= dom_mem[dom_raddr];
        idom_rd_reg <= idom_mem[idom_raddr];
        fr_rd_reg   <= fr_mem[i_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_rd_reg <= 1'b0;
            fv_rd_reg <= 1'b0;
        end
        else
        begin
            pv_rd_reg <= pred_vld_reg[i_a];
            fv_rd_reg <= fr_vld_reg[i_a];
        end
    end

    // edge loading into predecessor rows
    always_ff @(posedge clk)
    begin
        if (in_xfer && edge_valid && ({1'b0, edge_from} < cfg_n_reg)
            && ({1'b0, edge_to} < cfg_n_reg))
        begin
            if (pred_vld_reg[edge_to[IW-1:0]])
                pred_mem[edge_to[IW-1:0]][edge_from] <= 1'b1;
            else
                pred_mem[edge_to[IW-1:0]] <= RW'(1) << edge_from;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pred_vld_reg <= '0;
        else if (state_reg == dtb_pkg::ST_CLR)
            pred_vld_reg <= '0;
        else if (in_xfer && edge_valid && ({1'b0, edge_from} < cfg_n_reg)
                 && ({1'b0, edge_to} < cfg_n_reg))
            pred_vld_reg[edge_to[IW-1:0]] <= 1'b1;
    end

    // dominator and idom writes
    always_ff @(posedge clk)
    begin
        if (state_reg == dtb_pkg::ST_INIT)
            dom_mem[i_a] <= (i_reg == '0) ? RW'(1) : full_reg;
        else if (state_reg == dtb_pkg::ST_D_WR && dom_new != dom_rd_reg)
            dom_mem[i_a] <= dom_new;
        if (state_reg == dtb_pkg::ST_INIT && i_reg == '0)
            idom_mem[i_a] <= '0;
        else if (state_reg == dtb_pkg::ST_I_WR)
            idom_mem[i_a] <= {have_reg, pick_reg};
    end

    // frontier bit writes
    always_ff @(posedge clk)
    begin
        if (state_reg == dtb_pkg::ST_F_WUSE)
        begin
            if (fr_vld_reg[cur_a])
                fr_mem[cur_a][i_reg[XW-1:0]] <= 1'b1;
            else
                fr_mem[cur_a] <= i_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_vld_reg <= '0;
        else if (state_reg == dtb_pkg::ST_INIT && i_reg == '0)
            fr_vld_reg <= '0;
        else if (state_reg == dtb_pkg::ST_F_WUSE)
            fr_vld_reg[cur_a] <= 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        steps_next   = steps_reg;
        cur_next     = cur_reg;
        cv_next      = cv_reg;
        changed_next = changed_reg;
        have_next    = have_reg;
        pick_next    = pick_reg;
        full_next    = full_reg;
        prow_next    = prow_reg;
        acc_next     = acc_reg;
        idi_next     = idi_reg;
        if (state_reg == dtb_pkg::ST_IDLE)
            n_next = cfg_n_reg;
        case (state_reg)
            dtb_pkg::ST_IDLE:
            begin
                if (in_xfer && final_item)
                begin
                    i_next = '0;
                    full_next = cfg_n_reg[CW-1] ? {RW{1'b1}}
                                : ((RW'(1) << cfg_n_reg[XW-1:0]) - RW'(1));
                    state_next = dtb_pkg::ST_INIT;
                end
            end
            dtb_pkg::ST_INIT:
            begin
                if (i_reg + CW'(1) == n_reg)
                begin
                    changed_next = 1'b0;
                    if (n_reg == CW'(1))
                    begin
                        i_next = '0;
                        state_next = dtb_pkg::ST_F_RD;
                    end
                    else
                    begin
                        i_next = CW'(1);
                        state_next = dtb_pkg::ST_D_PRD;
                    end
                end
                else
                    i_next = i_reg + CW'(1);
            end
            dtb_pkg::ST_D_PRD:
                state_next = dtb_pkg::ST_D_PROW;
            dtb_pkg::ST_D_PROW:
            begin
                prow_next = pv_rd_reg ? (pred_rd_reg & full_reg) : '0;
                acc_next = full_reg;
                j_next = '0;
                state_next = dtb_pkg::ST_D_JRD;
            end
            dtb_pkg::ST_D_JRD:
                state_next = dtb_pkg::ST_D_JUSE;
            dtb_pkg::ST_D_JUSE:
            begin
                if (prow_reg[j_reg[XW-1:0]])
                    acc_next = acc_reg & dom_rd_reg;
                j_next = j_reg + CW'(1);
                state_next = (j_reg + CW'(1) == n_reg) ? dtb_pkg::ST_D_ORD
                                                       : dtb_pkg::ST_D_JRD;
            end
            dtb_pkg::ST_D_ORD:
                state_next = dtb_pkg::ST_D_WR;
            dtb_pkg::ST_D_WR:
            begin
                if (i_reg + CW'(1) == n_reg)
                begin
                    i_next = CW'(1);
                    changed_next = 1'b0;
                    if (changed_reg || dom_new != dom_rd_reg)
                        state_next = dtb_pkg::ST_D_PRD;
                    else
                        state_next = dtb_pkg::ST_I_RRD;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    if (dom_new != dom_rd_reg)
                        changed_next = 1'b1;
                    state_next = dtb_pkg::ST_D_PRD;
                end
            end
            dtb_pkg::ST_I_RRD:
                state_next = dtb_pkg::ST_I_ROW;
            dtb_pkg::ST_I_ROW:
            begin
                prow_next = dom_rd_reg;
                have_next = 1'b0;
                pick_next = '0;
                j_next = '0;
                state_next = dtb_pkg::ST_I_JRD;
            end
            dtb_pkg::ST_I_JRD:
                state_next = dtb_pkg::ST_I_JUSE;
            dtb_pkg::ST_I_JUSE:
            begin
                if (j_reg != i_reg && prow_reg[j_reg[XW-1:0]]
                    && (!have_reg || dom_rd_reg[pick_reg]))
                begin
                    pick_next = j_reg[XW-1:0];
                    have_next = 1'b1;
                end
                j_next = j_reg + CW'(1);
                state_next = (j_reg + CW'(1) == n_reg) ? dtb_pkg::ST_I_WR
                                                       : dtb_pkg::ST_I_JRD;
            end
            dtb_pkg::ST_I_WR:
            begin
                if (i_reg + CW'(1) == n_reg)
                begin
                    i_next = '0;
                    state_next = dtb_pkg::ST_F_RD;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = dtb_pkg::ST_I_RRD;
                end
            end
            dtb_pkg::ST_F_RD:
                state_next = dtb_pkg::ST_F_ROW;
            dtb_pkg::ST_F_ROW:
            begin
                prow_next = pv_rd_reg ? (pred_rd_reg & full_reg) : '0;
                idi_next = idom_rd_reg;
                j_next = '0;
                state_next = dtb_pkg::ST_F_J;
            end
            dtb_pkg::ST_F_J:
            begin
                if (j_reg == n_reg)
                begin
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) == n_reg)
                    begin
                        i_next = '0;
                        state_next = dtb_pkg::ST_O_RD;
                    end
                    else
                        state_next = dtb_pkg::ST_F_RD;
                end
                else if (prow_reg[j_reg[XW-1:0]])
                begin
                    cur_next = j_reg[XW-1:0];
                    steps_next = '0;
                    cv_next = 1'b1;
                    state_next = dtb_pkg::ST_F_WRD;
                end
                else
                    j_next = j_reg + CW'(1);
            end
            dtb_pkg::ST_F_WRD:
            begin
                if (steps_reg == n_reg || !cv_reg
                    || (idi_reg[DW-1] && idi_reg[XW-1:0] == cur_reg))
                begin
                    j_next = j_reg + CW'(1);
                    state_next = dtb_pkg::ST_F_J;
                end
                else
                    state_next = dtb_pkg::ST_F_WUSE;
            end
            dtb_pkg::ST_F_WUSE:
            begin
                cur_next = idom_rd_reg[XW-1:0];
                cv_next = idom_rd_reg[DW-1];
                steps_next = steps_reg + CW'(1);
                state_next = dtb_pkg::ST_F_WRD;
            end
            dtb_pkg::ST_O_RD:
                state_next = dtb_pkg::ST_O_LOAD;
            dtb_pkg::ST_O_LOAD:
            begin
                if (out_free)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = (i_reg + CW'(1) == n_reg) ? dtb_pkg::ST_CLR
                                                           : dtb_pkg::ST_O_RD;
                end
            end
            dtb_pkg::ST_CLR:
                state_next = dtb_pkg::ST_IDLE;
            default:
                state_next = dtb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dtb_pkg::ST_IDLE;
            n_reg       <= CW'(1);
            i_reg       <= '0;
            j_reg       <= '0;
            steps_reg   <= '0;
            cur_reg     <= '0;
            cv_reg      <= 1'b0;
            changed_reg <= 1'b0;
            have_reg    <= 1'b0;
            pick_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            steps_reg   <= steps_next;
            cur_reg     <= cur_next;
            cv_reg      <= cv_next;
            changed_reg <= changed_next;
            have_reg    <= have_next;
            pick_reg    <= pick_next;
        end
    end

    // datapath rows
    always_ff @(posedge clk)
    begin
        full_reg <= full_next;
        prow_reg <= prow_next;
        acc_reg  <= acc_next;
        idi_reg  <= idi_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (o_load)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_idx_reg  <= i_reg[XW-1:0];
            o_dom_reg  <= dom_rd_reg;
            o_ip_reg   <= idom_rd_reg[DW-1];
            o_id_reg   <= idom_rd_reg[DW-1] ? idom_rd_reg[XW-1:0] : '0;
            o_fr_reg   <= fv_rd_reg ? fr_rd_reg : '0;
            o_last_reg <= (i_reg + CW'(1) == n_reg);
        end
    end

    assign out_valid           = ov_reg;
    assign node_index          = o_idx_reg;
    assign dominator_set       = o_dom_reg;
    assign idom_present        = o_ip_reg;
    assign immediate_dominator = o_id_reg;
    assign frontier_set        = o_fr_reg;
    assign last_node           = o_last_reg;

    // checks
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == dtb_pkg::ST_O_LOAD))
        else $error("result appeared outside output phase");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_last_reg) |-> (CW'(o_idx_reg) + CW'(1) == n_reg))
        else $error("last marker on wrong node");

    a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && final_item) |=> (state_reg == dtb_pkg::ST_INIT))
        else $error("final item did not start analysis");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtb_pkg::ST_F_WUSE) |-> (steps_reg < n_reg))
        else $error("frontier walk exceeded node count");

    a_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtb_pkg::ST_D_WR || state_reg == dtb_pkg::ST_I_WR)
        |-> (i_reg < n_reg && i_reg != '0))
        else $error("row index out of range");

endmodule

`default_nettype wire
